>>> rtl/sgr_pkg.sv
package sgr_pkg;

    // Default grid size: GRID_N inner cells, GRID_N+2 cells per side
    localparam int GRID_N_DEF = 30;

    // Fraction bits of the cell-unit fixed-point values
    localparam int FRAC_BITS = 15;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int COORD_W = 16;
    localparam int CELL_W  = 5;
    localparam int MASK_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        SHAPE_POINT   = 2'd0,
        SHAPE_SQUARE  = 2'd1,
        SHAPE_CIRCLE  = 2'd2,
        SHAPE_DIAMOND = 2'd3
    } shape_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_BOX,
        ST_XSQ,
        ST_BASE,
        ST_PROBE,
        ST_PROBE_WAIT,
        ST_ROWS,
        ST_FALLBACK,
        ST_DRAIN
    } ctrl_state_t;

    // What a slot in the row pipeline carries
    typedef enum logic [1:0] {
        TAG_ROW,
        TAG_PROBE,
        TAG_FALLBACK
    } row_tag_t;

    // Operand of the shared squarer
    typedef enum logic [1:0] {
        SQ_DY,
        SQ_RAD,
        SQ_CTR
    } sq_sel_t;

    typedef struct packed {
        logic              capture;
        logic              scale_load;
        logic              box_load;
        logic              sq_load;
        sq_sel_t           sq_sel;
        logic              base_init;
        logic              base_sub;
        logic              probe_clear;
        logic              issue;
        row_tag_t          issue_tag;
        logic [CELL_W-1:0] issue_y;
        logic              issue_last;
    } sgr_cmd_t;

    typedef struct packed {
        logic              issue_ok;
        logic              pipe_empty;
        logic              scan_ok;
        logic              probe_done;
        logic              probe_hit;
        logic [CELL_W-1:0] ymin;
        logic [CELL_W-1:0] ymax;
        logic [CELL_W-1:0] probe_row;
    } sgr_sts_t;

endpackage

>>> rtl/sgr_datapath.sv
module sgr_datapath #(
    parameter int GRID_N = sgr_pkg::GRID_N_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sgr_pkg::sgr_cmd_t                      cmd,
    output sgr_pkg::sgr_sts_t                      sts,
    input  logic [sgr_pkg::KIND_W-1:0]             shape_kind,
    input  logic signed [sgr_pkg::COORD_W-1:0]     center_x,
    input  logic signed [sgr_pkg::COORD_W-1:0]     center_y,
    input  logic [sgr_pkg::COORD_W-1:0]            radius,
    input  logic                                   out_stall,
    output logic                                   out_valid,
    output logic [sgr_pkg::CELL_W-1:0]             row_index,
    output logic [sgr_pkg::MASK_W-1:0]             column_mask,
    output logic                                   last_row
);
    import sgr_pkg::*;

    // Working width of cell-unit values, and of their squares
    localparam int DW = 20 + $clog2(GRID_N + 3);
    localparam int SW = 2 * DW;
    localparam int CELL_MAX_I = (GRID_N + 1 < MASK_W - 1) ? GRID_N + 1 : MASK_W - 1;

    localparam logic [CELL_W-1:0]    CELL_MAX   = CELL_W'(CELL_MAX_I);
    localparam logic signed [DW-1:0] CELL_MAX_S = DW'(CELL_MAX_I);
    localparam logic signed [DW-1:0] CTR_SCALE  = DW'(GRID_N + 2);
    localparam logic signed [DW-1:0] RAD_SCALE  = DW'(GRID_N);
    localparam logic signed [DW-1:0] ONE_Q14    = DW'(1 << (FRAC_BITS - 1));
    localparam logic signed [DW-1:0] CEIL_BIAS  = DW'((1 << FRAC_BITS) - 1);
    localparam logic signed [DW-1:0] ROUND_BIAS = DW'(1 << (FRAC_BITS - 1));
    localparam logic signed [SW-1:0] THR_OPEN   = {1'b0, {(SW - 1){1'b1}}};

    // Round half away from zero, then saturate to the grid
    function automatic logic [CELL_W-1:0] round_cell(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] t;
        t = (v + ROUND_BIAS) >>> FRAC_BITS;
        if (v[DW-1])
            return '0;
        else if (t > CELL_MAX_S)
            return CELL_MAX;
        else
            return t[CELL_W-1:0];
    endfunction

    // Captured item
    shape_t                     kind_reg;
    logic signed [COORD_W-1:0]  cx_reg;
    logic signed [COORD_W-1:0]  cy_reg;
    logic [COORD_W-1:0]         rad_reg;

    // Scaled center and radius
    logic signed [DW-1:0] xc_reg, xc_next;
    logic signed [DW-1:0] yc_reg, yc_next;
    logic signed [DW-1:0] rq_reg, rq_next;

    // Box and lanes
    logic [CELL_W-1:0]    ymin_reg, ymin_next;
    logic [CELL_W-1:0]    ymax_reg, ymax_next;
    logic [CELL_W-1:0]    cx_rnd_reg, cx_rnd_next;
    logic [CELL_W-1:0]    cy_rnd_reg, cy_rnd_next;
    logic [MASK_W-1:0]    box_mask_reg, box_mask_next;
    logic                 scan_ok_reg, scan_ok_next;
    logic signed [SW-1:0] lane_reg  [MASK_W];
    logic signed [SW-1:0] lane_next [MASK_W];

    // Squarer and circle threshold base
    logic signed [DW-1:0] sq_op;
    logic signed [SW-1:0] sq_reg, sq_next;
    logic signed [SW-1:0] base_reg, base_next;

    // Row pipeline
    logic                 adv;
    logic                 s1_valid_reg;
    row_tag_t             s1_tag_reg;
    logic [CELL_W-1:0]    s1_y_reg;
    logic                 s1_last_reg;
    logic signed [DW-1:0] dy_reg, dy_next;
    logic                 s2_valid_reg;
    row_tag_t             s2_tag_reg;
    logic [CELL_W-1:0]    s2_y_reg;
    logic                 s2_last_reg;
    logic signed [DW-1:0] ady_reg, ady_next;

    // Mask stage and output register
    logic signed [SW-1:0] thr;
    logic [MASK_W-1:0]    row_mask;
    logic                 out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]    row_reg, row_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic                 last_reg, last_next;
    logic                 probe_done_reg, probe_done_next;
    logic                 probe_hit_reg, probe_hit_next;

    // Scale to cell units with FRAC_BITS fraction bits
    always_comb
    begin
        xc_next = (DW'(cx_reg) + ONE_Q14) * CTR_SCALE;
        yc_next = (DW'(cy_reg) + ONE_Q14) * CTR_SCALE;
        rq_next = $signed(DW'(rad_reg)) * RAD_SCALE;
    end

    // Clamped bounding box, rounded center, per-column lane values
    always_comb
    begin
        logic signed [DW-1:0] fl_x, cl_x, fl_y, cl_y, dxk;
        logic                 ok_x, ok_y;
        logic [CELL_W-1:0]    xmin, xmax;
        fl_x = (xc_reg - rq_reg) >>> FRAC_BITS;
        cl_x = (xc_reg + rq_reg + CEIL_BIAS) >>> FRAC_BITS;
        fl_y = (yc_reg - rq_reg) >>> FRAC_BITS;
        cl_y = (yc_reg + rq_reg + CEIL_BIAS) >>> FRAC_BITS;
        ok_x = (fl_x <= CELL_MAX_S) && !cl_x[DW-1];
        ok_y = (fl_y <= CELL_MAX_S) && !cl_y[DW-1];
        xmin = fl_x[DW-1] ? '0 : fl_x[CELL_W-1:0];
        xmax = (cl_x > CELL_MAX_S) ? CELL_MAX : cl_x[CELL_W-1:0];
        ymin_next = fl_y[DW-1] ? '0 : fl_y[CELL_W-1:0];
        ymax_next = (cl_y > CELL_MAX_S) ? CELL_MAX : cl_y[CELL_W-1:0];
        scan_ok_next = ok_x && ok_y && (kind_reg != SHAPE_POINT);
        cx_rnd_next = round_cell(xc_reg);
        cy_rnd_next = round_cell(yc_reg);
        for (int k = 0; k < MASK_W; k++)
        begin
            box_mask_next[k] = (CELL_W'(k) >= xmin) && (CELL_W'(k) <= xmax);
            dxk = (DW'(k) <<< FRAC_BITS) - xc_reg;
            if (kind_reg == SHAPE_DIAMOND)
                lane_next[k] = SW'(dxk[DW-1] ? -dxk : dxk);
            else
                // dx^2 less the xc^2 term, which sits in the threshold base
                lane_next[k] = (SW'(k * k) <<< (2 * FRAC_BITS))
                             - ((SW'(xc_reg) * SW'(k)) <<< (FRAC_BITS + 1));
        end
    end

    assign adv = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (cmd.sq_sel)
            SQ_RAD:  sq_op = rq_reg;
            SQ_CTR:  sq_op = xc_reg;
            SQ_DY:   sq_op = dy_reg;
            default: sq_op = dy_reg;
        endcase
        sq_next   = sq_op * sq_op;
        base_next = base_reg;
        if (cmd.base_init)
            base_next = sq_reg;
        else if (cmd.base_sub)
            base_next = base_reg - sq_reg;
        dy_next  = ($signed(DW'(cmd.issue_y)) <<< FRAC_BITS) - yc_reg;
        ady_next = dy_reg[DW-1] ? -dy_reg : dy_reg;
    end

    // Row test: threshold against every lane
    always_comb
    begin
        unique case (kind_reg)
            SHAPE_CIRCLE:              thr = base_reg - sq_reg;
            SHAPE_DIAMOND:             thr = SW'(rq_reg) - SW'(ady_reg);
            SHAPE_POINT, SHAPE_SQUARE: thr = THR_OPEN;
        endcase
        for (int k = 0; k < MASK_W; k++)
            row_mask[k] = box_mask_reg[k] && (lane_reg[k] <= thr);
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        row_next        = row_reg;
        mask_next       = mask_reg;
        last_next       = last_reg;
        probe_done_next = probe_done_reg;
        probe_hit_next  = probe_hit_reg;
        if (adv)
        begin
            out_valid_next = 1'b0;
            if (s2_valid_reg)
            begin
                unique case (s2_tag_reg)
                    TAG_ROW:
                    begin
                        out_valid_next = 1'b1;
                        row_next       = s2_y_reg;
                        mask_next      = row_mask;
                        last_next      = s2_last_reg;
                    end
                    TAG_FALLBACK:
                    begin
                        out_valid_next = 1'b1;
                        row_next       = cy_rnd_reg;
                        mask_next      = MASK_W'(1) << cx_rnd_reg;
                        last_next      = 1'b1;
                    end
                    TAG_PROBE:
                    begin
                        probe_done_next = 1'b1;
                        probe_hit_next  = |row_mask;
                    end
                    default:
                    begin
                        out_valid_next = 1'b0;
                    end
                endcase
            end
        end
        if (cmd.probe_clear)
            probe_done_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= shape_t'(shape_kind);
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            rad_reg  <= radius;
        end
        if (cmd.scale_load)
        begin
            xc_reg <= xc_next;
            yc_reg <= yc_next;
            rq_reg <= rq_next;
        end
        if (cmd.box_load)
        begin
            ymin_reg     <= ymin_next;
            ymax_reg     <= ymax_next;
            cx_rnd_reg   <= cx_rnd_next;
            cy_rnd_reg   <= cy_rnd_next;
            box_mask_reg <= box_mask_next;
            lane_reg     <= lane_next;
        end
        if (cmd.sq_load || (adv && s1_valid_reg))
            sq_reg <= sq_next;
        base_reg <= base_next;
        if (adv)
        begin
            s1_tag_reg  <= cmd.issue_tag;
            s1_y_reg    <= cmd.issue_y;
            s1_last_reg <= cmd.issue_last;
            dy_reg      <= dy_next;
            s2_tag_reg  <= s1_tag_reg;
            s2_y_reg    <= s1_y_reg;
            s2_last_reg <= s1_last_reg;
            ady_reg     <= ady_next;
        end
        row_reg  <= row_next;
        mask_reg <= mask_next;
        last_reg <= last_next;
        probe_hit_reg <= probe_hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_ok_reg    <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            probe_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.box_load)
                scan_ok_reg <= scan_ok_next;
            if (adv)
            begin
                s1_valid_reg <= cmd.issue;
                s2_valid_reg <= s1_valid_reg;
            end
            out_valid_reg  <= out_valid_next;
            probe_done_reg <= probe_done_next;
        end
    end

    always_comb
    begin
        sts.issue_ok   = adv;
        sts.pipe_empty = !s1_valid_reg && !s2_valid_reg;
        sts.scan_ok    = scan_ok_reg;
        sts.probe_done = probe_done_reg;
        sts.probe_hit  = probe_hit_reg;
        sts.ymin       = ymin_reg;
        sts.ymax       = ymax_reg;
        if (cy_rnd_reg < ymin_reg)
            sts.probe_row = ymin_reg;
        else if (cy_rnd_reg > ymax_reg)
            sts.probe_row = ymax_reg;
        else
            sts.probe_row = cy_rnd_reg;
    end

    assign out_valid   = out_valid_reg;
    assign row_index   = row_reg;
    assign column_mask = mask_reg;
    assign last_row    = last_reg;

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv && s2_valid_reg |=> s2_valid_reg && $stable(sq_reg))
        else $error("row pipeline moved while the output was blocked");

    a_probe_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(probe_done_reg) |-> $past(s2_valid_reg && s2_tag_reg == TAG_PROBE))
        else $error("probe result without a probe in the pipeline");

    a_fallback_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s2_valid_reg && s2_tag_reg == TAG_FALLBACK |=> $onehot(mask_reg) && last_reg)
        else $error("fallback beat is not a single cell");

endmodule

>>> rtl/sgr_ctrl.sv
module sgr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sgr_pkg::sgr_sts_t sts,
    output sgr_pkg::sgr_cmd_t cmd
);
    import sgr_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [CELL_W-1:0] row_reg, row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        cmd            = '0;
        cmd.sq_sel     = SQ_DY;
        cmd.issue_tag  = TAG_ROW;
        cmd.issue_y    = row_reg;
        cmd.issue_last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_load = 1'b1;
                state_next     = ST_BOX;
            end
            ST_BOX:
            begin
                cmd.box_load = 1'b1;
                cmd.sq_load  = 1'b1;
                cmd.sq_sel   = SQ_RAD;
                state_next   = ST_XSQ;
            end
            ST_XSQ:
            begin
                cmd.sq_load     = 1'b1;
                cmd.sq_sel      = SQ_CTR;
                cmd.base_init   = 1'b1;
                cmd.probe_clear = 1'b1;
                state_next      = ST_BASE;
            end
            ST_BASE:
            begin
                cmd.base_sub = 1'b1;
                state_next   = sts.scan_ok ? ST_PROBE : ST_FALLBACK;
            end
            ST_PROBE:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_tag = TAG_PROBE;
                cmd.issue_y   = sts.probe_row;
                if (sts.issue_ok)
                    state_next = ST_PROBE_WAIT;
            end
            ST_PROBE_WAIT:
            begin
                if (sts.probe_done)
                begin
                    row_next   = sts.ymin;
                    state_next = sts.probe_hit ? ST_ROWS : ST_FALLBACK;
                end
            end
            ST_ROWS:
            begin
                cmd.issue      = 1'b1;
                cmd.issue_last = (row_reg == sts.ymax);
                if (sts.issue_ok)
                begin
                    if (row_reg == sts.ymax)
                        state_next = ST_DRAIN;
                    else
                        row_next = row_reg + 1'b1;
                end
            end
            ST_FALLBACK:
            begin
                cmd.issue      = 1'b1;
                cmd.issue_tag  = TAG_FALLBACK;
                cmd.issue_last = 1'b1;
                if (sts.issue_ok)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                    state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    a_row_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROWS |-> (row_reg >= sts.ymin) && (row_reg <= sts.ymax))
        else $error("row counter left the bounding box");

    a_scan_only_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROWS || state_reg == ST_PROBE) |-> sts.scan_ok)
        else $error("row scan started on an empty box");

endmodule

>>> rtl/shape_grid_rasterizer.sv
// Sequence: the input beat is captured; setup and the probe row precede the first row mask.
// Occupancy: a box of R rows (R up to 32) holds the block for setup, probe and the rows;
//   a point or empty box for setup and a fallback beat; a box with no cell hit also probes.
// Throughput: the row pipeline issues one row per cycle; the next input beat is taken
//   once the last row has left the two-stage row pipeline. Output stalls freeze it.
// Reset: asynchronous, active low; clears the controller and all valid flags, no clearing pass.
module shape_grid_rasterizer #(
    parameter int GRID_N = sgr_pkg::GRID_N_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Shape input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sgr_pkg::KIND_W-1:0]         shape_kind,
    input  logic signed [sgr_pkg::COORD_W-1:0] center_x,
    input  logic signed [sgr_pkg::COORD_W-1:0] center_y,
    input  logic [sgr_pkg::COORD_W-1:0]        radius,
    // Row mask output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sgr_pkg::CELL_W-1:0]         row_index,
    output logic [sgr_pkg::MASK_W-1:0]         column_mask,
    output logic                               last_row
);
    import sgr_pkg::*;

    // The controller sequences setup (scale, box and lanes, squares), then, unless the box
    // is empty or the shape a point, a probe of the row nearest the center: if the probe row
    // is empty, no box row is covered and, as with no probe, one fallback beat of the rounded
    // center cell goes out; else box rows issue in rising order, one per cycle unless stalled.
    sgr_cmd_t cmd;
    sgr_sts_t sts;

    sgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the column lanes (one compare per column), the shared
    // squarer, and the row pipeline feeding the output register.
    sgr_datapath #(
        .GRID_N (GRID_N)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .shape_kind  (shape_kind),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .row_index   (row_index),
        .column_mask (column_mask),
        .last_row    (last_row)
    );

endmodule
